/* hw/rtl/knn_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and cell command codes for the k-nearest-neighbour classifier.
package knn_pkg;

	// Table and neighbour sizing
	localparam int TABLE_DEPTH   = 32;
	localparam int MAX_NEIGHBORS = 7;
	localparam int CLASS_COUNT   = 8;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int NB_W  = $clog2(MAX_NEIGHBORS + 1);

	// Item field widths
	localparam int OP_W    = 1;
	localparam int ENTRY_W = 5;
	localparam int F1_W    = 8;
	localparam int F2_W    = 16;
	localparam int CLASS_W = $clog2(CLASS_COUNT);
	localparam int VOTE_W  = 3;

	// Squared distance: sum of two squares, the wider one 2*F2_W bits
	localparam int DIST_W = 2 * F2_W + 1;

	// Stream packing
	localparam int F1_LSB       = ENTRY_W;
	localparam int F2_LSB       = ENTRY_W + F1_W;
	localparam int CLS_LSB      = ENTRY_W + F1_W + F2_W;
	localparam int IN_FIELDS_W  = ENTRY_W + F1_W + F2_W + CLASS_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_TUSER_W   = OP_W;
	localparam int OUT_FIELDS_W = CLASS_W + VOTE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// Item kinds
	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	// Configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int ENTRIES_W  = 6;
	localparam int NEIGH_W    = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 1'd1;
	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 6'd20;
	localparam logic [NEIGH_W-1:0]   NEIGH_RESET   = 3'd3;

	// Cell commands
	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRIM   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd4;

	// Reference table entry
	typedef struct packed {
		logic [F1_W-1:0]    f1;
		logic [F2_W-1:0]    f2;
		logic [CLASS_W-1:0] cls;
	} tbl_entry_t;

	// Contents of one neighbour cell
	typedef struct packed {
		logic               valid;
		logic [DIST_W-1:0]  sqd;
		logic [CLASS_W-1:0] cls;
	} cell_t;

	// Broadcast control to the cell row: command and candidate
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [DIST_W-1:0]  sqd;
		logic [CLASS_W-1:0] cls;
	} cell_ctrl_t;

endpackage

/* hw/rtl/knn_table.sv */
`timescale 1ns / 1ps
// Reference table memory: one write port, one registered read port.
module knn_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [knn_pkg::IDX_W-1:0] waddr,
	input  knn_pkg::tbl_entry_t     wdata,
	input  logic                    re,
	input  logic [knn_pkg::IDX_W-1:0] raddr,
	output knn_pkg::tbl_entry_t     rd_data_s1,
	output logic                    rd_valid_s1
);

	knn_pkg::tbl_entry_t mem_q [knn_pkg::TABLE_DEPTH];

	// Storage and read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_s1 <= mem_q[raddr];
		end
	end

	// Read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
		end
	end

endmodule

/* hw/rtl/knn_dist.sv */
`timescale 1ns / 1ps
// Squared distance pipeline: differences, squares, sum.
module knn_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [knn_pkg::F1_W-1:0]   q_f1,
	input  logic [knn_pkg::F2_W-1:0]   q_f2,
	input  logic                       in_valid,
	input  knn_pkg::tbl_entry_t        in_entry,
	output logic                       out_valid,
	output logic [knn_pkg::DIST_W-1:0] out_dist,
	output logic [knn_pkg::CLASS_W-1:0] out_cls,
	output logic                       busy
);

	logic [knn_pkg::F1_W-1:0]    da_s2;
	logic [knn_pkg::F2_W-1:0]    db_s2;
	logic [knn_pkg::CLASS_W-1:0] cls_s2;
	logic                        valid_s2;
	logic [2*knn_pkg::F1_W-1:0]  sqa_s3;
	logic [2*knn_pkg::F2_W-1:0]  sqb_s3;
	logic [knn_pkg::CLASS_W-1:0] cls_s3;
	logic                        valid_s3;
	logic [knn_pkg::DIST_W-1:0]  dist_s4;
	logic [knn_pkg::CLASS_W-1:0] cls_s4;
	logic                        valid_s4;

	// Data path
	always_ff @(posedge clk) begin
		// absolute differences
		da_s2  <= (q_f1 > in_entry.f1) ? q_f1 - in_entry.f1 : in_entry.f1 - q_f1;
		db_s2  <= (q_f2 > in_entry.f2) ? q_f2 - in_entry.f2 : in_entry.f2 - q_f2;
		cls_s2 <= in_entry.cls;
		// squares
		sqa_s3 <= (2*knn_pkg::F1_W)'(da_s2) * (2*knn_pkg::F1_W)'(da_s2);
		sqb_s3 <= (2*knn_pkg::F2_W)'(db_s2) * (2*knn_pkg::F2_W)'(db_s2);
		cls_s3 <= cls_s2;
		// sum
		dist_s4 <= knn_pkg::DIST_W'(sqa_s3) + knn_pkg::DIST_W'(sqb_s3);
		cls_s4  <= cls_s3;
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_dist  = dist_s4;
	assign out_cls   = cls_s4;
	assign busy      = valid_s2 | valid_s3 | valid_s4;

endmodule

/* hw/rtl/knn_cell.sv */
`timescale 1ns / 1ps
// One neighbour cell of the sorted insertion row.
module knn_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  knn_pkg::cell_ctrl_t ctrl,
	input  logic                keep,
	input  knn_pkg::cell_t      prev_entry,
	input  logic                prev_take,
	input  knn_pkg::cell_t      next_entry,
	output knn_pkg::cell_t      entry,
	output logic                take
);

	logic                        valid_q;
	logic [knn_pkg::DIST_W-1:0]  dist_q;
	logic [knn_pkg::CLASS_W-1:0] cls_q;

	// Candidate belongs here or earlier: strictly nearer, or cell empty
	assign take = !valid_q || (ctrl.sqd < dist_q);

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				knn_pkg::CMD_CLEAR: valid_q <= 1'b0;
				knn_pkg::CMD_INSERT: begin
					if (take) begin
						valid_q <= prev_take ? prev_entry.valid : 1'b1;
					end
				end
				knn_pkg::CMD_TRIM: begin
					if (!keep) begin
						valid_q <= 1'b0;
					end
				end
				knn_pkg::CMD_SHIFT: valid_q <= next_entry.valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	// Distance and class
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			knn_pkg::CMD_INSERT: begin
				if (take) begin
					dist_q <= prev_take ? prev_entry.sqd : ctrl.sqd;
					cls_q  <= prev_take ? prev_entry.cls : ctrl.cls;
				end
			end
			knn_pkg::CMD_SHIFT: begin
				dist_q <= next_entry.sqd;
				cls_q  <= next_entry.cls;
			end
			default: begin
				dist_q <= dist_q;
				cls_q  <= cls_q;
			end
		endcase
	end

	assign entry.valid = valid_q;
	assign entry.sqd   = dist_q;
	assign entry.cls   = cls_q;

endmodule

/* hw/rtl/knn_vote.sv */
`timescale 1ns / 1ps
// Forward vote over the head cell, keeping the first strictly larger count.
module knn_vote (
	input  logic                        clk,
	input  logic                        clear,
	input  logic                        step,
	input  knn_pkg::cell_t              cells [knn_pkg::MAX_NEIGHBORS],
	output logic [knn_pkg::CLASS_W-1:0] best_cls,
	output logic [knn_pkg::NB_W-1:0]    best_count
);

	logic [knn_pkg::NB_W-1:0]    count;
	logic [knn_pkg::CLASS_W-1:0] best_cls_q;
	logic [knn_pkg::NB_W-1:0]    best_count_q;

	// Head plus matching later neighbours
	always_comb begin
		count = knn_pkg::NB_W'(1);
		for (int j = 1; j < knn_pkg::MAX_NEIGHBORS; j++) begin
			if (cells[j].valid && (cells[j].cls == cells[0].cls)) begin
				count = count + knn_pkg::NB_W'(1);
			end
		end
	end

	// Running best
	always_ff @(posedge clk) begin
		if (clear) begin
			best_cls_q   <= '0;
			best_count_q <= '0;
		end else if (step && cells[0].valid && (count > best_count_q)) begin
			best_cls_q   <= cells[0].cls;
			best_count_q <= count;
		end
	end

	assign best_cls   = best_cls_q;
	assign best_count = best_count_q;

endmodule

/* hw/rtl/knn_majority_classifier.sv */
`timescale 1ns / 1ps
// Top level of the two-feature k-nearest-neighbour classifier.
//
// A write request (tuser op = 0) stores a reference entry and gives no result.
// A query request (op = 1) scans the first entries_in_use table slots, one per cycle through
// the single table read port, into the squared-distance pipeline; each distance is
// inserted into a row of MAX_NEIGHBORS sorted cells (equal distances keep the lower slot
// first). The row is then trimmed to neighbors_used and shifted out head first, one voter a
// cycle, to find the winning class. No new request is taken until the result sits in the
// output register; a held result does not block the next request. Every slot a query
// searches must have been written first.
module knn_majority_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	// entry_index, first_feature, second_feature, class_label
	input  logic [knn_pkg::IN_TDATA_W-1:0]   s_tdata,
	// op
	input  logic [knn_pkg::IN_TUSER_W-1:0]   s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// predicted_class, winning_votes, zero pad
	output logic [knn_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [knn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_TRIM  = 3'd3;
	localparam logic [2:0] ST_VOTE  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                       state_q;
	logic [knn_pkg::ENTRIES_W-1:0]    entries_q;
	logic [knn_pkg::NEIGH_W-1:0]      neighbors_q;
	logic [knn_pkg::CNT_W-1:0]        n_q;
	logic [knn_pkg::NB_W-1:0]         k_q;
	logic [knn_pkg::IDX_W-1:0]        scan_idx_q;
	logic [knn_pkg::F1_W-1:0]         q_f1_q;
	logic [knn_pkg::F2_W-1:0]         q_f2_q;
	logic                             out_valid_q;
	logic [knn_pkg::OUT_TDATA_W-1:0]  out_data_q;

	logic                             in_accept;
	logic [knn_pkg::OP_W-1:0]         in_op;
	logic [knn_pkg::ENTRY_W-1:0]      in_idx;
	knn_pkg::tbl_entry_t              in_entry;
	logic                             query_start;
	logic                             tbl_we;
	logic                             scan_last;
	logic                             out_free;
	logic [knn_pkg::CNT_W-1:0]        n_next;
	logic [knn_pkg::NB_W-1:0]         k_next;

	knn_pkg::tbl_entry_t              rd_data_s1;
	logic                             rd_valid_s1;
	logic                             dist_valid;
	logic [knn_pkg::DIST_W-1:0]       dist_val;
	logic [knn_pkg::CLASS_W-1:0]      dist_cls;
	logic                             dist_busy;

	knn_pkg::cell_ctrl_t              cell_ctrl;
	knn_pkg::cell_t                   cells [knn_pkg::MAX_NEIGHBORS];
	logic                             takes [knn_pkg::MAX_NEIGHBORS];
	logic [knn_pkg::CLASS_W-1:0]      best_cls;
	logic [knn_pkg::NB_W-1:0]         best_count;

	// Request unpacking
	assign in_op        = s_tuser[knn_pkg::OP_W-1:0];
	assign in_idx       = s_tdata[knn_pkg::ENTRY_W-1:0];
	assign in_entry.f1  = s_tdata[knn_pkg::F1_LSB +: knn_pkg::F1_W];
	assign in_entry.f2  = s_tdata[knn_pkg::F2_LSB +: knn_pkg::F2_W];
	assign in_entry.cls = s_tdata[knn_pkg::CLS_LSB +: knn_pkg::CLASS_W];

	assign s_tready    = (state_q == ST_IDLE);
	assign in_accept   = s_tvalid && s_tready;
	assign query_start = in_accept && (in_op == knn_pkg::OP_QUERY);
	assign tbl_we      = in_accept && (in_op == knn_pkg::OP_WRITE) &&
		({1'b0, in_idx} < (knn_pkg::ENTRY_W + 1)'(knn_pkg::TABLE_DEPTH));
	assign scan_last   = (knn_pkg::CNT_W'(scan_idx_q) == n_q - knn_pkg::CNT_W'(1));
	assign out_free    = !out_valid_q || m_tready;
	assign cfg_ready   = 1'b1;

	// Clamp the counts to their usable ranges
	always_comb begin
		if (entries_q == '0) begin
			n_next = knn_pkg::CNT_W'(1);
		end else if (32'(entries_q) > knn_pkg::TABLE_DEPTH) begin
			n_next = knn_pkg::CNT_W'(knn_pkg::TABLE_DEPTH);
		end else begin
			n_next = knn_pkg::CNT_W'(entries_q);
		end
		if (neighbors_q == '0) begin
			k_next = knn_pkg::NB_W'(1);
		end else if (32'(neighbors_q) > knn_pkg::MAX_NEIGHBORS) begin
			k_next = knn_pkg::NB_W'(knn_pkg::MAX_NEIGHBORS);
		end else begin
			k_next = knn_pkg::NB_W'(neighbors_q);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= knn_pkg::ENTRIES_RESET;
			neighbors_q <= knn_pkg::NEIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				knn_pkg::REG_ENTRIES:   entries_q   <= cfg_data[knn_pkg::ENTRIES_W-1:0];
				knn_pkg::REG_NEIGHBORS: neighbors_q <= cfg_data[knn_pkg::NEIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			n_q        <= knn_pkg::CNT_W'(1);
			k_q        <= knn_pkg::NB_W'(1);
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						n_q        <= n_next;
						k_q        <= k_next;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + knn_pkg::IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !dist_busy) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: state_q <= ST_VOTE;
				ST_VOTE: begin
					if (!cells[0].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query point
	always_ff @(posedge clk) begin
		if (query_start) begin
			q_f1_q <= in_entry.f1;
			q_f2_q <= in_entry.f2;
		end
	end

	knn_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.we          (tbl_we),
		.waddr       (knn_pkg::IDX_W'(in_idx)),
		.wdata       (in_entry),
		.re          (state_q == ST_SCAN),
		.raddr       (scan_idx_q),
		.rd_data_s1  (rd_data_s1),
		.rd_valid_s1 (rd_valid_s1)
	);

	knn_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_f1      (q_f1_q),
		.q_f2      (q_f2_q),
		.in_valid  (rd_valid_s1),
		.in_entry  (rd_data_s1),
		.out_valid (dist_valid),
		.out_dist  (dist_val),
		.out_cls   (dist_cls),
		.busy      (dist_busy)
	);

	// Cell row command
	always_comb begin
		cell_ctrl.sqd = dist_val;
		cell_ctrl.cls = dist_cls;
		if (query_start) begin
			cell_ctrl.cmd = knn_pkg::CMD_CLEAR;
		end else if (dist_valid) begin
			cell_ctrl.cmd = knn_pkg::CMD_INSERT;
		end else if (state_q == ST_TRIM) begin
			cell_ctrl.cmd = knn_pkg::CMD_TRIM;
		end else if ((state_q == ST_VOTE) && cells[0].valid) begin
			cell_ctrl.cmd = knn_pkg::CMD_SHIFT;
		end else begin
			cell_ctrl.cmd = knn_pkg::CMD_HOLD;
		end
	end

	// Sorted neighbour row
	for (genvar i = 0; i < knn_pkg::MAX_NEIGHBORS; i++) begin : g_cell
		knn_pkg::cell_t prev_entry;
		knn_pkg::cell_t next_entry;
		logic           prev_take;

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_take  = 1'b0;
		end else begin : g_body
			assign prev_entry = cells[i-1];
			assign prev_take  = takes[i-1];
		end

		if (i == knn_pkg::MAX_NEIGHBORS - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_link
			assign next_entry = cells[i+1];
		end

		knn_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.keep       (knn_pkg::NB_W'(i) < k_q),
			.prev_entry (prev_entry),
			.prev_take  (prev_take),
			.next_entry (next_entry),
			.entry      (cells[i]),
			.take       (takes[i])
		);
	end

	knn_vote u_vote (
		.clk        (clk),
		.clear      (query_start),
		.step       (state_q == ST_VOTE),
		.cells      (cells),
		.best_cls   (best_cls),
		.best_count (best_count)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q <= {{knn_pkg::OUT_PAD_W{1'b0}},
				knn_pkg::VOTE_W'(best_count), best_cls};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* hw/rtl/knn_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the classifier, bound to the top level.
module knn_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [knn_pkg::IN_TUSER_W-1:0]  s_tuser,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [knn_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every result carries at least one vote
	a_votes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[knn_pkg::CLASS_W +: knn_pkg::VOTE_W] != '0))
		else $error("result with zero votes");

	// A query occupies the block: no request taken in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == knn_pkg::OP_QUERY) |=> !s_tready)
		else $error("request taken while a query runs");

	// A new result only appears at the end of a query
	a_result_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

endmodule

bind knn_majority_classifier knn_checker u_knn_checker (.*);
